// ===== sv/rrts_pkg.sv =====
// Shared types and constants of the round-robin time-slice scheduler.
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int unsigned IdW    = 8;
  localparam int unsigned LenW   = 8;
  localparam int unsigned TickW  = 16;
  localparam int unsigned SliceW = 8;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgSliceLength     = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgAdmissionWindow = 1'd1;

  localparam logic [SliceW-1:0] SliceLengthReset     = 8'd4;
  localparam logic [TickW-1:0]  AdmissionWindowReset = 16'd100;
  localparam logic [TickW-1:0]  TickMax              = 16'hFFFF;
  localparam logic [LenW-1:0]   ServedMax            = 8'hFF;

  localparam logic FuncArrival = 1'b0;
  localparam logic FuncTick    = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_SHIFT = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [LenW-1:0]  need;
    logic [LenW-1:0]  served;
    logic [TickW-1:0] start;
    logic             started;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   data;
  } cell_ctrl_t;

  typedef struct packed {
    logic             func;
    logic [IdW-1:0]   job_id;
    logic [LenW-1:0]  job_length;
  } in_item_t;

  typedef struct packed {
    logic             idle;
    logic [IdW-1:0]   running_id;
    logic             finished;
    logic [TickW-1:0] first_tick;
    logic [TickW-1:0] last_tick;
    logic             all_done;
  } out_item_t;

endpackage

// ===== sv/rrts_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per beat.
`timescale 1ns / 1ps

interface rrts_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rrts_cell.sv =====
// One queue entry of the scheduler; shifts from its upper neighbor on removal.
`timescale 1ns / 1ps

module rrts_cell #(
  parameter int unsigned SlotW = 4,
  parameter int unsigned Idx   = 0
) (
  input  logic               clk_i,
  input  rrts_pkg::cell_ctrl_t ctrl_i,
  input  logic [SlotW-1:0]   sel_i,
  input  rrts_pkg::entry_t   nb_i,
  output rrts_pkg::entry_t   entry_o
);

  localparam logic [SlotW-1:0] MyIdx = SlotW'(Idx);

  rrts_pkg::entry_t entry_q;
  rrts_pkg::entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      rrts_pkg::CELL_LOAD: begin
        if (sel_i == MyIdx) entry_d = ctrl_i.data;
      end
      rrts_pkg::CELL_SHIFT: begin
        // Entries at and above the removed slot move down by one place.
        if (MyIdx >= sel_i) entry_d = nb_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== sv/round_robin_time_slice_scheduler.sv =====
// Top level of the round-robin time-slice scheduler: control and cell row.
`timescale 1ns / 1ps

// Usage:
// in_i carries items: func 0 appends a job (id, length) to the ready queue,
// func 1 is one scheduler tick. out_o carries one result beat per tick and
// none per arrival: the served job id or idle, a finished flag with the job's
// first and last tick, and all_done once the window has passed and the
// queue is empty. cfg_we_i/cfg_idx_i/cfg_wdata_i write slice_length (index 0)
// and admission_window (index 1); write them only while the block is idle.
// The queue is a row of QueueDepth cells; removing an entry shifts all cells
// above it down by one place together.
// A tick passes a choose step, a serve step and an output step, and its
// result is then registered; an idle or done tick skips the serve step.
// Every unstarted job dropped after the window adds another serve and
// choose step. A new item is taken once the previous one is done, while
// its result may still wait in the output register; a stalled receiver
// holds the next tick result in the output stage.
// Reset clears the queue count, tick counter and selection and loads the
// register defaults (slice 4, window 100); queue contents need no clearing.
module round_robin_time_slice_scheduler #(
  parameter int unsigned QueueDepth = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rrts_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rrts_pkg::CfgW-1:0]       cfg_wdata_i,
  rrts_stream_if.sink                     in_i,
  rrts_stream_if.source                   out_o
);

  localparam int unsigned SlotW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(QueueDepth);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHOOSE = 2'd1;
  localparam logic [1:0] ST_SERVE  = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [SlotW-1:0]             slot_q, slot_d;
  logic                         cur_vld_q, cur_vld_d;
  logic [rrts_pkg::SliceW-1:0]  used_q, used_d;
  logic [rrts_pkg::TickW-1:0]   tick_q, tick_d;
  logic [rrts_pkg::SliceW-1:0]  slice_len_q;
  logic [rrts_pkg::TickW-1:0]   window_q;
  rrts_pkg::out_item_t          res_q, res_d;
  logic                         out_vld_q, out_vld_d;
  rrts_pkg::out_item_t          out_data_q;
  logic                         out_load;

  rrts_pkg::cell_ctrl_t         ctrl;
  logic [SlotW-1:0]             sel;
  rrts_pkg::entry_t             entries [QueueDepth];
  rrts_pkg::entry_t             cur;
  rrts_pkg::entry_t             upd;

  logic                         in_acc;
  logic                         late;
  logic [rrts_pkg::TickW-1:0]   tick_inc;
  logic [CntW-1:0]              slot_ext;
  logic [CntW-1:0]              slot_nx;
  logic [CntW-1:0]              cnt_dec;

  // Row of queue cells.
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    rrts_pkg::entry_t nb;
    if (i == QueueDepth - 1) begin : g_last
      assign nb = entries[i];
    end else begin : g_mid
      assign nb = entries[i+1];
    end
    rrts_cell #(
      .SlotW (SlotW),
      .Idx   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .sel_i   (sel),
      .nb_i    (nb),
      .entry_o (entries[i])
    );
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign late       = (tick_q >= window_q);
  assign tick_inc   = (tick_q != rrts_pkg::TickMax) ? tick_q + 1'b1 : tick_q;
  assign slot_ext   = CntW'(slot_q);
  assign slot_nx    = slot_ext + 1'b1;
  assign cnt_dec    = cnt_q - 1'b1;
  assign cur        = entries[slot_q];
  assign out_load   = (state_q == ST_EMIT) && (!out_vld_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    slot_d    = slot_q;
    cur_vld_d = cur_vld_q;
    used_d    = used_q;
    tick_d    = tick_q;
    res_d     = res_q;
    ctrl      = '{op: rrts_pkg::CELL_HOLD, data: cur};
    sel       = slot_q;
    upd       = cur;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.data.func == rrts_pkg::FuncTick) begin
            state_d = ST_CHOOSE;
          end else if (!late && cnt_q < CntMax) begin
            ctrl.op           = rrts_pkg::CELL_LOAD;
            ctrl.data.id      = in_i.data.job_id;
            ctrl.data.need    = in_i.data.job_length;
            ctrl.data.served  = '0;
            ctrl.data.start   = '0;
            ctrl.data.started = 1'b0;
            sel               = cnt_q[SlotW-1:0];
            cnt_d             = cnt_q + 1'b1;
          end
        end
      end

      ST_CHOOSE: begin
        res_d = '0;
        if (late && cnt_q == '0) begin
          res_d.idle     = 1'b1;
          res_d.all_done = 1'b1;
          state_d        = ST_EMIT;
        end else begin
          if (!cur_vld_q || slot_ext >= cnt_q) begin
            used_d    = '0;
            slot_d    = '0;
            cur_vld_d = (cnt_q != '0);
          end else if (used_q == slice_len_q) begin
            used_d = '0;
            slot_d = (slot_nx >= cnt_q) ? '0 : slot_nx[SlotW-1:0];
          end
          if (!cur_vld_d) begin
            res_d.idle = 1'b1;
            tick_d     = tick_inc;
            state_d    = ST_EMIT;
          end else begin
            state_d = ST_SERVE;
          end
        end
      end

      ST_SERVE: begin
        if (late && !cur.started) begin
          // Unstarted job after the window: drop it and choose again.
          ctrl.op   = rrts_pkg::CELL_SHIFT;
          cnt_d     = cnt_dec;
          cur_vld_d = (slot_ext < cnt_dec);
          used_d    = '0;
          state_d   = ST_CHOOSE;
        end else begin
          upd = cur;
          if (!cur.started) begin
            upd.start   = tick_q;
            upd.started = 1'b1;
          end
          if (cur.served != rrts_pkg::ServedMax) upd.served = cur.served + 1'b1;
          res_d.running_id = cur.id;
          used_d           = used_q + 1'b1;
          if (upd.served >= upd.need) begin
            res_d.finished   = 1'b1;
            res_d.first_tick = upd.start;
            res_d.last_tick  = tick_q;
            ctrl.op          = rrts_pkg::CELL_SHIFT;
            cnt_d            = cnt_dec;
            cur_vld_d        = (slot_ext < cnt_dec);
            used_d           = '0;
          end else begin
            ctrl.op   = rrts_pkg::CELL_LOAD;
            ctrl.data = upd;
          end
          tick_d  = tick_inc;
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_load) state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_vld_d = out_load | (out_vld_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      slot_q      <= '0;
      cur_vld_q   <= 1'b0;
      used_q      <= '0;
      tick_q      <= '0;
      slice_len_q <= rrts_pkg::SliceLengthReset;
      window_q    <= rrts_pkg::AdmissionWindowReset;
      out_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      slot_q    <= slot_d;
      cur_vld_q <= cur_vld_d;
      used_q    <= used_d;
      tick_q    <= tick_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rrts_pkg::CfgSliceLength:     slice_len_q <= cfg_wdata_i[rrts_pkg::SliceW-1:0];
          rrts_pkg::CfgAdmissionWindow: window_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) out_data_q <= res_q;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("queue count exceeds depth");

  a_arrival_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.data.func == rrts_pkg::FuncArrival && !late && cnt_q < CntMax
    |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("admitted arrival did not enter the queue");

  a_serve_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SERVE |-> cur_vld_q && slot_ext < cnt_q)
    else $error("serving a slot outside the queue");

  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.data.func == rrts_pkg::FuncTick |=> state_q == ST_CHOOSE)
    else $error("accepted tick did not start a choose step");

  a_tick_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |=> tick_q >= $past(tick_q))
    else $error("tick counter went backward");

endmodule

// ===== tb/rrts_sched_checker.sv =====
// Scoreboard for the round-robin scheduler: predicts each tick report and compares beats.
`timescale 1ns / 1ps

module rrts_sched_checker #(
  parameter int unsigned QueueDepth = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rrts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rrts_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  rrts_pkg::in_item_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  rrts_pkg::out_item_t           out_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   results_due_o,
  output int unsigned                   jobs_queued_o,
  output logic [rrts_pkg::TickW-1:0]    tick_now_o
);

  // Shadow of the ready queue and the selection state.
  logic [rrts_pkg::IdW-1:0]    rq_id     [QueueDepth];
  logic [rrts_pkg::LenW-1:0]   rq_need   [QueueDepth];
  logic [rrts_pkg::LenW-1:0]   rq_served [QueueDepth];
  logic [rrts_pkg::TickW-1:0]  rq_first  [QueueDepth];
  logic                        rq_ran    [QueueDepth];
  int unsigned                 rq_len = 0;
  int unsigned                 sel_slot = 0;
  logic                        sel_valid = 1'b0;
  logic [rrts_pkg::SliceW-1:0] quantum_used = '0;
  logic [rrts_pkg::TickW-1:0]  now_tick = '0;
  logic [rrts_pkg::SliceW-1:0] quantum = rrts_pkg::SliceLengthReset;
  logic [rrts_pkg::TickW-1:0]  cutoff = rrts_pkg::AdmissionWindowReset;
  int unsigned                 mismatches = 0;

  rrts_pkg::out_item_t tick_reports_q[$];

  task automatic step_tick_count();
    if (now_tick != rrts_pkg::TickMax) now_tick++;
  endtask

  // Removing an entry closes the gap and hands a fresh slice to the entry that slides in.
  task automatic remove_job(input int unsigned idx);
    for (int unsigned i = idx; i + 1 < rq_len; i++) begin
      rq_id[i]     = rq_id[i + 1];
      rq_need[i]   = rq_need[i + 1];
      rq_served[i] = rq_served[i + 1];
      rq_first[i]  = rq_first[i + 1];
      rq_ran[i]    = rq_ran[i + 1];
    end
    rq_len--;
    sel_slot     = idx;
    sel_valid    = (idx < rq_len);
    quantum_used = '0;
  endtask

  task automatic admit_job(input logic [rrts_pkg::IdW-1:0] id,
                           input logic [rrts_pkg::LenW-1:0] need);
    if (now_tick < cutoff && rq_len < QueueDepth) begin
      rq_id[rq_len]     = id;
      rq_need[rq_len]   = need;
      rq_served[rq_len] = '0;
      rq_first[rq_len]  = '0;
      rq_ran[rq_len]    = 1'b0;
      rq_len++;
    end
  endtask

  task automatic schedule_tick(output rrts_pkg::out_item_t rep);
    logic        late;
    logic        choosing;
    int unsigned s;
    rep      = '0;
    s        = 0;
    choosing = 1'b1;
    // After the window, jobs that never ran are dropped as they come up for selection.
    while (choosing) begin
      late = (now_tick >= cutoff);
      if (late && rq_len == 0) begin
        rep.idle     = 1'b1;
        rep.all_done = 1'b1;
        return;
      end
      if (!sel_valid || sel_slot >= rq_len) begin
        quantum_used = '0;
        sel_slot     = 0;
        sel_valid    = (rq_len > 0);
      end else if (quantum_used == quantum) begin
        quantum_used = '0;
        sel_slot++;
        if (sel_slot >= rq_len) sel_slot = 0;
      end
      if (!sel_valid) begin
        rep.idle = 1'b1;
        step_tick_count();
        return;
      end
      s = sel_slot;
      if (late && !rq_ran[s]) remove_job(s);
      else choosing = 1'b0;
    end
    rep.running_id = rq_id[s];
    quantum_used++;
    if (!rq_ran[s]) begin
      rq_first[s] = now_tick;
      rq_ran[s]   = 1'b1;
    end
    if (rq_served[s] != rrts_pkg::ServedMax) rq_served[s]++;
    if (rq_served[s] >= rq_need[s]) begin
      rep.finished   = 1'b1;
      rep.first_tick = rq_first[s];
      rep.last_tick  = now_tick;
      remove_job(s);
    end
    step_tick_count();
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rrts_pkg::out_item_t want;
    rrts_pkg::out_item_t rep;
    if (!rst_ni) begin
      tick_reports_q.delete();
      rq_len       = 0;
      sel_slot     = 0;
      sel_valid    = 1'b0;
      quantum_used = '0;
      now_tick     = '0;
      quantum      = rrts_pkg::SliceLengthReset;
      cutoff       = rrts_pkg::AdmissionWindowReset;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rrts_pkg::CfgSliceLength) begin
          quantum = cfg_wdata_i[rrts_pkg::SliceW-1:0];
        end else if (cfg_idx_i == rrts_pkg::CfgAdmissionWindow) begin
          cutoff = cfg_wdata_i[rrts_pkg::TickW-1:0];
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (tick_reports_q.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with no tick waiting, expected none, got id %0d idle %0d",
                   $time, out_data_i.running_id, out_data_i.idle);
        end else begin
          want = tick_reports_q.pop_front();
          compare_field("idle", want.idle, out_data_i.idle);
          compare_field("running_id", want.running_id, out_data_i.running_id);
          compare_field("finished", want.finished, out_data_i.finished);
          compare_field("first_tick", want.first_tick, out_data_i.first_tick);
          compare_field("last_tick", want.last_tick, out_data_i.last_tick);
          compare_field("all_done", want.all_done, out_data_i.all_done);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.func == rrts_pkg::FuncArrival) begin
          admit_job(in_data_i.job_id, in_data_i.job_length);
        end else begin
          schedule_tick(rep);
          tick_reports_q.push_back(rep);
        end
      end
    end
    fail_count_o  = mismatches;
    results_due_o = tick_reports_q.size();
    jobs_queued_o = rq_len;
    tick_now_o    = now_tick;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: clock, reset, scheduler stimulus, result sink, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned QueueDepth   = 16;
  localparam int unsigned ClkPeriod    = 12;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned HoldAfter    = 300;

  localparam int unsigned IdW     = rrts_pkg::IdW;
  localparam int unsigned LenW    = rrts_pkg::LenW;
  localparam int unsigned SliceW  = rrts_pkg::SliceW;
  localparam int unsigned TickW   = rrts_pkg::TickW;
  localparam int unsigned CfgW    = rrts_pkg::CfgW;
  localparam int unsigned CfgIdxW = rrts_pkg::CfgIdxW;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;

  int unsigned        fail_count;
  int unsigned        results_due;
  int unsigned        jobs_queued;
  logic [TickW-1:0]   tick_now;

  int unsigned        quiet_cycles = 0;
  int unsigned        results_seen = 0;

  int unsigned        tx_left = 0;
  logic               tx_steady = 1'b0;

  rrts_stream_if #(.payload_t(rrts_pkg::in_item_t))  in_if ();
  rrts_stream_if #(.payload_t(rrts_pkg::out_item_t)) out_if ();

  round_robin_time_slice_scheduler #(
    .QueueDepth(QueueDepth)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  rrts_sched_checker #(
    .QueueDepth(QueueDepth)
  ) u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_if.valid),
    .in_ready_i    (in_if.ready),
    .in_data_i     (in_if.data),
    .out_valid_i   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .out_data_i    (out_if.data),
    .fail_count_o  (fail_count),
    .results_due_o (results_due),
    .jobs_queued_o (jobs_queued),
    .tick_now_o    (tick_now)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) results_seen <= results_seen + 1;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= StallLimit);
    $display("round_robin_time_slice_scheduler: mismatch");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LenW-1:0] job_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return LenW'($urandom_range(1, 6));
    if (r < 97) return LenW'($urandom_range(7, 16));
    if (r < 99) return '0;
    return LenW'($urandom_range(17, 40));
  endfunction

  function automatic rrts_pkg::in_item_t job_arrival(input logic [IdW-1:0] id,
                                                     input logic [LenW-1:0] len);
    rrts_pkg::in_item_t it;
    it.func       = rrts_pkg::FuncArrival;
    it.job_id     = id;
    it.job_length = len;
    return it;
  endfunction

  // The id and length bits of a tick are don't-care, so they carry noise.
  function automatic rrts_pkg::in_item_t clock_tick();
    rrts_pkg::in_item_t it;
    it.func       = rrts_pkg::FuncTick;
    it.job_id     = IdW'($urandom);
    it.job_length = LenW'($urandom);
    return it;
  endfunction

  task automatic push_item(input rrts_pkg::in_item_t item);
    int unsigned n;
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    do @(posedge clk); while (!in_if.ready);
    if (tx_left == 0) begin
      tx_left   = $urandom_range(20, 150);
      tx_steady = ($urandom_range(0, 2) == 0);
    end
    tx_left--;
    n = tx_steady ? 0 : gap_len();
    if (n != 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop offering until every tick report is back, then let the block settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Admission stays open for a number of ticks, then the queue drains until done.
  task automatic run_phase(input logic [SliceW-1:0] slice, input int unsigned ahead);
    int unsigned cut;
    int unsigned done_ticks;
    logic        late;
    drain();
    cut = tick_now + ahead;
    if (cut > rrts_pkg::TickMax) cut = rrts_pkg::TickMax;
    write_reg(rrts_pkg::CfgSliceLength, CfgW'(slice));
    write_reg(rrts_pkg::CfgAdmissionWindow, CfgW'(cut));
    done_ticks = 0;
    while (done_ticks < 3) begin
      late = (tick_now >= cut);
      if ($urandom_range(0, 99) < (late ? 3 : 45)) begin
        push_item(job_arrival(IdW'($urandom), job_len()));
      end else begin
        if (late && jobs_queued == 0) done_ticks++;
        push_item(clock_tick());
      end
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  initial begin : result_sink
    int unsigned stretch;
    int unsigned n;
    logic        steady;
    logic        held_long;
    stretch   = 0;
    steady    = 1'b0;
    held_long = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stretch == 0) begin
        stretch = $urandom_range(20, 300);
        steady  = ($urandom_range(0, 2) == 0);
      end
      stretch--;
      if (!held_long && results_seen >= HoldAfter) begin
        // One long back-pressure window so the block fills up and stalls its input.
        held_long = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else begin
        n = steady ? 0 : gap_len();
        if (n != 0) begin
          out_if.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    cfg_we      <= 1'b0;
    cfg_idx     <= rrts_pkg::CfgSliceLength;
    cfg_wdata   <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick on an empty queue, id and length extremes, a full queue.
    push_item(clock_tick());
    push_item(job_arrival(8'd0, 8'd1));
    push_item(job_arrival(8'd255, 8'd0));
    push_item(job_arrival(8'h5A, 8'd255));
    repeat (14) push_item(job_arrival(IdW'($urandom), LenW'($urandom_range(1, 3))));
    repeat (3) push_item(clock_tick());
    // Window already passed: arrivals are refused and unstarted jobs are dropped.
    drain();
    write_reg(rrts_pkg::CfgAdmissionWindow, CfgW'(1));
    push_item(job_arrival(8'hC3, 8'd7));
    repeat (3) push_item(clock_tick());

    run_phase(8'd1, 40);
    run_phase(8'd255, 80);
    run_phase(8'd0, 50);
    run_phase(8'd2, 90);
    repeat (3) run_phase(SliceW'($urandom_range(1, 16)), $urandom_range(0, 100));

    drain();
    if (fail_count == 0) begin
      $display("round_robin_time_slice_scheduler: match");
    end else begin
      $display("round_robin_time_slice_scheduler: mismatch");
    end
    $finish;
  end

endmodule
